// File: sv/inc_pkg.sv
// shared types and constants of the inverse normal cdf pipeline
`timescale 1ns / 1ps

package inc_pkg;

    // input probability width, bits above it are ignored
    localparam int PROB_BITS = 32;

    // fixed-point widths along the datapath
    localparam int LOG_FRAC = 28;
    localparam int U_W      = 34;
    localparam int U_LO_W   = 17;
    localparam int S_W      = 54;
    localparam int T_W      = 27;
    localparam int ROOT_REM = 28;
    localparam int H_W      = 32;
    localparam int QUOT_W   = 28;
    localparam int Z_W      = 29;
    localparam int MAG_W    = 28;
    localparam int RND_W    = 37;

    // 2 ln 2 in Q.30
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

    // rational approximation coefficients in Q.24
    localparam logic [H_W-1:0] NUM_C0 = 32'd42203372;
    localparam logic [H_W-1:0] NUM_C1 = 32'd13469638;
    localparam logic [H_W-1:0] NUM_C2 = 32'd173275;
    localparam logic [H_W-1:0] DEN_D0 = 32'd24038194;
    localparam logic [H_W-1:0] DEN_D1 = 32'd3175407;
    localparam logic [H_W-1:0] DEN_D2 = 32'd21945;
    localparam logic [H_W-1:0] ONE_Q24 = 32'd16777216;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MEAN = 1'b0,
        REG_STD  = 1'b1
    } cfg_reg_t;

    // per-transaction flags that travel beside the data
    typedef struct packed {
        logic zero;
        logic lower;
    } side_t;

endpackage

// File: sv/inc_log2.sv
// pipelined -2 ln(q) unit: normalize, 28 squaring stages, scale by 2 ln 2
`timescale 1ns / 1ps

module inc_log2 (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  inc_pkg::side_t           in_side,
    input  logic [31:0]              in_q,
    output logic                     out_valid,
    output inc_pkg::side_t           out_side,
    output logic [inc_pkg::S_W-1:0]  out_s
);

    localparam int L = inc_pkg::LOG_FRAC;

    logic [31:0]             x_reg    [0:L];
    logic [L-1:0]            frac_reg [0:L];
    logic [4:0]              lz_reg   [0:L];
    logic                    v_reg    [0:L];
    inc_pkg::side_t          side_reg [0:L];

    logic [4:0]              lz_next;
    logic                    found;

    logic [inc_pkg::U_W-1:0] u_reg;
    logic                    u_v_reg;
    inc_pkg::side_t          u_side_reg;
    logic [47:0]             plo_reg;
    logic [47:0]             phi_reg;
    logic                    p_v_reg;
    inc_pkg::side_t          p_side_reg;
    logic [64:0]             full_sum;
    logic [inc_pkg::S_W-1:0] s_reg;
    logic                    s_v_reg;
    inc_pkg::side_t          s_side_reg;

    // leading zero count of q (q is never zero here)
    always_comb begin
        lz_next = 5'd0;
        found   = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found) begin
                if (in_q[i]) begin
                    found = 1'b1;
                end else begin
                    lz_next = lz_next + 5'd1;
                end
            end
        end
    end

    // normalize stage: mantissa as Q1.31
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= in_q << lz_next;
            frac_reg[0] <= '0;
            lz_reg[0]   <= lz_next;
            side_reg[0] <= in_side;
        end
    end

    // one fraction bit per squaring stage
    for (genvar i = 0; i < L; i++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] sh;
        assign sq = 64'(x_reg[i]) * 64'(x_reg[i]);
        assign sh = sq[63:31];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= sh[32] ? sh[32:1] : sh[31:0];
                frac_reg[i+1] <= {frac_reg[i][L-2:0], sh[32]};
                lz_reg[i+1]   <= lz_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // u = ((32 - k) << 28) - frac, with 32 - k = lz + 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end else if (en) begin
            u_v_reg <= v_reg[L];
            p_v_reg <= u_v_reg;
            s_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg      <= {(6'(lz_reg[L]) + 6'd1), {L{1'b0}}}
                          - inc_pkg::U_W'(frac_reg[L]);
            u_side_reg <= side_reg[L];
        end
    end

    // scale by 2 ln 2 as two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg    <= 48'(u_reg[inc_pkg::U_LO_W-1:0]) * 48'(inc_pkg::TWO_LN2_Q30);
            phi_reg    <= 48'(u_reg[inc_pkg::U_W-1:inc_pkg::U_LO_W])
                          * 48'(inc_pkg::TWO_LN2_Q30);
            p_side_reg <= u_side_reg;
        end
    end

    assign full_sum = (65'(phi_reg) << inc_pkg::U_LO_W) + 65'(plo_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg      <= full_sum[63:10];
            s_side_reg <= p_side_reg;
        end
    end

    assign out_valid = s_v_reg;
    assign out_side  = s_side_reg;
    assign out_s     = s_reg;

endmodule

// File: sv/inc_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module inc_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  inc_pkg::side_t           in_side,
    input  logic [inc_pkg::S_W-1:0]  in_s,
    output logic                     out_valid,
    output inc_pkg::side_t           out_side,
    output logic [inc_pkg::T_W-1:0]  out_t
);

    localparam int N  = inc_pkg::T_W;
    localparam int RW = inc_pkg::ROOT_REM;

    logic [inc_pkg::S_W-1:0] s_reg    [0:N-1];
    logic [N-1:0]            root_reg [0:N-1];
    logic [RW-1:0]           rem_reg  [0:N-1];
    logic                    v_reg    [0:N-1];
    inc_pkg::side_t          side_reg [0:N-1];

    for (genvar j = 0; j < N; j++) begin : g_root
        logic [inc_pkg::S_W-1:0] s_prev;
        logic [N-1:0]            root_prev;
        logic [RW-1:0]           rem_prev;
        logic                    v_prev;
        inc_pkg::side_t          side_prev;
        logic [RW+1:0]           cur;
        logic [RW+1:0]           trial;
        logic                    ge;

        if (j == 0) begin : g_first
            assign s_prev    = in_s;
            assign root_prev = '0;
            assign rem_prev  = '0;
            assign v_prev    = in_valid;
            assign side_prev = in_side;
        end else begin : g_next
            assign s_prev    = s_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign v_prev    = v_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        // bring down two radicand bits and try root*4+1
        assign cur   = {rem_prev, s_prev[inc_pkg::S_W-1-2*j -: 2]};
        assign trial = (RW+2)'({root_prev, 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[j]    <= s_prev;
                root_reg[j] <= {root_prev[N-2:0], ge};
                rem_reg[j]  <= RW'(ge ? cur - trial : cur);
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_t     = root_reg[N-1];

endmodule

// File: sv/inc_ratio.sv
// rational term: two horner chains and a pipelined restoring divider
`timescale 1ns / 1ps

module inc_ratio (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  inc_pkg::side_t             in_side,
    input  logic [inc_pkg::T_W-1:0]    in_t,
    output logic                       out_valid,
    output inc_pkg::side_t             out_side,
    output logic [inc_pkg::T_W-1:0]    out_t,
    output logic [inc_pkg::QUOT_W-1:0] out_quot
);

    localparam int HW = inc_pkg::H_W;
    localparam int QW = inc_pkg::QUOT_W;
    localparam int TW = inc_pkg::T_W;
    localparam int PW = HW + TW;

    logic [HW-1:0]   a_reg, b1_reg, num2_reg, b2_reg, num3_reg, den_reg;
    logic [TW-1:0]   t1_reg, t2_reg, t3_reg;
    logic            v1_reg, v2_reg, v3_reg;
    inc_pkg::side_t  sd1_reg, sd2_reg, sd3_reg;
    logic [PW-1:0]   pa1, pb1, pa2, pb2, pb3;

    logic [HW-1:0]   rem_reg  [0:QW-1];
    logic [QW-1:0]   lo_reg   [0:QW-1];
    logic [HW-1:0]   dv_reg   [0:QW-1];
    logic [QW-1:0]   quot_reg [0:QW-1];
    logic [TW-1:0]   t_reg    [0:QW-1];
    logic            v_reg    [0:QW-1];
    inc_pkg::side_t  side_reg [0:QW-1];

    // horner products, each registered before the next
    assign pa1 = PW'(inc_pkg::NUM_C2) * PW'(in_t);
    assign pb1 = PW'(inc_pkg::DEN_D2) * PW'(in_t);
    assign pa2 = PW'(a_reg) * PW'(t1_reg);
    assign pb2 = PW'(b1_reg) * PW'(t1_reg);
    assign pb3 = PW'(b2_reg) * PW'(t2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= HW'(pa1 >> 24) + inc_pkg::NUM_C1;
            b1_reg   <= HW'(pb1 >> 24) + inc_pkg::DEN_D1;
            t1_reg   <= in_t;
            sd1_reg  <= in_side;
            num2_reg <= HW'(pa2 >> 24) + inc_pkg::NUM_C0;
            b2_reg   <= HW'(pb2 >> 24) + inc_pkg::DEN_D0;
            t2_reg   <= t1_reg;
            sd2_reg  <= sd1_reg;
            num3_reg <= num2_reg;
            den_reg  <= HW'(pb3 >> 24) + inc_pkg::ONE_Q24;
            t3_reg   <= t2_reg;
            sd3_reg  <= sd2_reg;
        end
    end

    // (num << 24) / den, one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [HW-1:0]  rem_prev;
        logic [QW-1:0]  lo_prev;
        logic [HW-1:0]  dv_prev;
        logic [QW-1:0]  quot_prev;
        logic [TW-1:0]  t_prev;
        logic           v_prev;
        inc_pkg::side_t side_prev;
        logic [HW:0]    r2;
        logic           ge;

        if (j == 0) begin : g_first
            assign rem_prev  = HW'(num3_reg[HW-1:HW-QW]);
            assign lo_prev   = {num3_reg[HW-QW-1:0], 24'd0};
            assign dv_prev   = den_reg;
            assign quot_prev = '0;
            assign t_prev    = t3_reg;
            assign v_prev    = v3_reg;
            assign side_prev = sd3_reg;
        end else begin : g_next
            assign rem_prev  = rem_reg[j-1];
            assign lo_prev   = lo_reg[j-1];
            assign dv_prev   = dv_reg[j-1];
            assign quot_prev = quot_reg[j-1];
            assign t_prev    = t_reg[j-1];
            assign v_prev    = v_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        assign r2 = {rem_prev, lo_prev[QW-1-j]};
        assign ge = r2 >= {1'b0, dv_prev};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= HW'(ge ? r2 - {1'b0, dv_prev} : r2);
                lo_reg[j]   <= lo_prev;
                dv_reg[j]   <= dv_prev;
                quot_reg[j] <= {quot_prev[QW-2:0], ge};
                t_reg[j]    <= t_prev;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign out_t     = t_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];

endmodule

// File: sv/inverse_normal_cdf_approx_top.sv
// top level: fold, log/sqrt/rational pipeline, scaling and saturation
`timescale 1ns / 1ps
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata[31:0] prob_fraction
//  m_        out  m_tvalid/m_tready  m_tdata[31:0] quantile_value,
//                                    m_tuser[0] out_of_range, [1] saturated
//  cfg       in   cfg_wr_en          cfg_index, cfg_wr_data
//
//  one transaction accepted per cycle while the output is not stalled; the pipeline
//  includes the 28 squaring stages of the log, 27 square root stages and 28 divider stages
//  the whole pipeline advances together and holds while a result waits
//  reset clears all valid bits; mean resets to 0, std_dev to 1.0

module inverse_normal_cdf_approx_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // prob_fraction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // quantile_value
    output logic [1:0]  m_tuser,      // out_of_range, saturated
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    localparam int ZW = inc_pkg::Z_W;
    localparam int MW = inc_pkg::MAG_W;
    localparam int RW = inc_pkg::RND_W;

    logic                        en;
    logic [31:0]                 mean_reg;
    logic [31:0]                 std_reg;

    logic [31:0]                 p_in;
    logic                        f_v_reg;
    inc_pkg::side_t              f_side_reg;
    logic [31:0]                 q_reg;

    logic                        l_v;
    inc_pkg::side_t              l_side;
    logic [inc_pkg::S_W-1:0]     l_s;
    logic                        r_v;
    inc_pkg::side_t              r_side;
    logic [inc_pkg::T_W-1:0]     r_t;
    logic                        d_v;
    inc_pkg::side_t              d_side;
    logic [inc_pkg::T_W-1:0]     d_t;
    logic [inc_pkg::QUOT_W-1:0]  d_quot;

    logic [ZW-1:0]               z_raw;
    logic [ZW-1:0]               z_sgn;
    logic                        z_v_reg;
    logic                        z_zero_reg;
    logic                        z_neg_reg;
    logic [MW-1:0]               z_mag_reg;

    logic                        m_v_reg;
    logic                        m_zero_reg;
    logic                        m_neg_reg;
    logic [59:0]                 m_prod_reg;

    logic [60:0]                 rnd_sum;
    logic [RW-1:0]               rnd;
    logic                        n_v_reg;
    logic                        n_zero_reg;
    logic [RW:0]                 n_val_reg;

    logic [RW+1:0]               x_sum;
    logic                        o_v_reg;
    logic [31:0]                 o_data_reg;
    logic                        o_oor_reg;
    logic                        o_sat_reg;

    assign en       = !o_v_reg || m_tready;
    assign s_tready = en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg <= 32'd0;
            std_reg  <= 32'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                inc_pkg::REG_MEAN: mean_reg <= cfg_wr_data;
                inc_pkg::REG_STD:  std_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // fold about one half
    assign p_in = s_tdata << (32 - inc_pkg::PROB_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (en) begin
            f_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg.zero  <= p_in == 32'd0;
            f_side_reg.lower <= !p_in[31];
            if (p_in == 32'd0) begin
                q_reg <= 32'd1;
            end else if (!p_in[31]) begin
                q_reg <= p_in;
            end else begin
                q_reg <= (~p_in) + 32'd1;
            end
        end
    end

    inc_log2 u_log2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_v_reg),
        .in_side   (f_side_reg),
        .in_q      (q_reg),
        .out_valid (l_v),
        .out_side  (l_side),
        .out_s     (l_s)
    );

    inc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (l_v),
        .in_side   (l_side),
        .in_s      (l_s),
        .out_valid (r_v),
        .out_side  (r_side),
        .out_t     (r_t)
    );

    inc_ratio u_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_v),
        .in_side   (r_side),
        .in_t      (r_t),
        .out_valid (d_v),
        .out_side  (d_side),
        .out_t     (d_t),
        .out_quot  (d_quot)
    );

    // z = t - quotient, negated for the lower half
    assign z_raw = ZW'(d_t) - ZW'(d_quot);
    assign z_sgn = d_side.lower ? -z_raw : z_raw;

    // final stages share the valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            n_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            z_v_reg <= d_v;
            m_v_reg <= z_v_reg;
            n_v_reg <= m_v_reg;
            o_v_reg <= n_v_reg;
        end
    end

    // sign and magnitude of z
    always_ff @(posedge aclk) begin
        if (en) begin
            z_zero_reg <= d_side.zero;
            z_neg_reg  <= z_sgn[ZW-1];
            z_mag_reg  <= MW'(z_sgn[ZW-1] ? -z_sgn : z_sgn);
        end
    end

    // magnitude times std_dev
    always_ff @(posedge aclk) begin
        if (en) begin
            m_zero_reg <= z_zero_reg;
            m_neg_reg  <= z_neg_reg;
            m_prod_reg <= 60'(z_mag_reg) * 60'(std_reg);
        end
    end

    // round to Q.16, ties away from zero, then apply sign
    assign rnd_sum = 61'(m_prod_reg) + 61'(24'h800000);
    assign rnd     = rnd_sum[60:24];

    always_ff @(posedge aclk) begin
        if (en) begin
            n_zero_reg <= m_zero_reg;
            n_val_reg  <= m_neg_reg ? -{1'b0, rnd} : {1'b0, rnd};
        end
    end

    // add mean and clamp to 32 bits
    assign x_sum = {n_val_reg[RW], n_val_reg}
                   + {{(RW-30){mean_reg[31]}}, mean_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            if (n_zero_reg) begin
                o_data_reg <= 32'd0;
                o_oor_reg  <= 1'b1;
                o_sat_reg  <= 1'b0;
            end else if (!x_sum[RW+1] && (x_sum[RW:31] != '0)) begin
                o_data_reg <= 32'h7fffffff;
                o_oor_reg  <= 1'b0;
                o_sat_reg  <= 1'b1;
            end else if (x_sum[RW+1] && (x_sum[RW:31] != '1)) begin
                o_data_reg <= 32'h80000000;
                o_oor_reg  <= 1'b0;
                o_sat_reg  <= 1'b1;
            end else begin
                o_data_reg <= x_sum[31:0];
                o_oor_reg  <= 1'b0;
                o_sat_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = {o_sat_reg, o_oor_reg};

`ifndef SYNTHESIS
    // a waiting result blocks new input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // zero probability gives a zero, unsaturated result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0 && !m_tuser[1])
        else $error("out of range result not cleared");

    // saturation only at the bounds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'h7fffffff || m_tdata == 32'h80000000)
        else $error("saturated result not at a bound");

    // pipeline is empty after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
